// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is asserted.
`define TLG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tlg assertion failed");

// Clocked assertion that also holds during reset.
`define TLG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tlg assertion failed");

`endif

// ----- hdl/tlg_pkg.sv -----
// Shared constants for the toroidal life generation block.
// No dependencies; imported by the lanes, the row engine, the top level and the checker.
`timescale 1ns / 1ps

package tlg_pkg;

  localparam int COLS_DEF = 64;
  localparam int ROWS_DEF = 32;

  localparam int ROW_W = 64;
  localparam int IDX_W = 5;
  localparam int FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EMIT    = 2'd2;

  localparam int NBR_CNT_W = 4;
  localparam logic [NBR_CNT_W-1:0] BIRTH_CNT   = 4'd3;
  localparam logic [NBR_CNT_W-1:0] SURVIVE_CNT = 4'd2;

endpackage

// ----- hdl/tlg_lane.sv -----
// One cell lane: counts the eight neighbors and applies rule B3/S23.
// Depends on tlg_pkg.
`timescale 1ns / 1ps

module tlg_lane
  import tlg_pkg::*;
(
  input  logic [7:0] nbr_i,
  input  logic       alive_i,
  output logic       next_o
);

  logic [NBR_CNT_W-1:0] count;

  always_comb begin
    count = '0;
    for (int k = 0; k < 8; k++) begin
      count = count + NBR_CNT_W'(nbr_i[k]);
    end
  end

  assign next_o = (count == BIRTH_CNT) || (alive_i && (count == SURVIVE_CNT));

endmodule

// ----- hdl/tlg_row_engine.sv -----
// Row engine: one tlg_lane per column with toroidal column wrap, merged into a row word.
// Depends on tlg_pkg and tlg_lane.
`timescale 1ns / 1ps

module tlg_row_engine
  import tlg_pkg::*;
#(
  parameter int COLS = COLS_DEF
) (
  input  logic [COLS-1:0] above_i,
  input  logic [COLS-1:0] cur_i,
  input  logic [COLS-1:0] below_i,
  output logic [COLS-1:0] next_o
);

  logic [COLS-1:0] lane_next;

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    localparam int L = (c + COLS - 1) % COLS;
    localparam int R = (c + 1) % COLS;

    tlg_lane u_lane (
      .nbr_i   ({above_i[L], above_i[c], above_i[R],
                 cur_i[L], cur_i[R],
                 below_i[L], below_i[c], below_i[R]}),
      .alive_i (cur_i[c]),
      .next_o  (lane_next[c])
    );
  end

  assign next_o = lane_next;

endmodule

// ----- hdl/toroidal_life_generation.sv -----
// Advance: accept, read the last row, row 0 and row 1, then one row per cycle; results are
// registered. Emit: accept, a read of row 0, then rows likewise. Load: written on accept.
// The single read port of the board memory sets the one-row-per-cycle pace. Output stalls
// hold the sweep in place. Reset clears control state and the per-row valid bits, so every
// row reads as dead until written; no clearing pass is needed.
`timescale 1ns / 1ps

module toroidal_life_generation
  import tlg_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [IDX_W-1:0]  row_index_i,
  input  logic [ROW_W-1:0]  row_bits_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IDX_W-1:0]  out_row_index_o,
  output logic [ROW_W-1:0]  out_row_bits_o,
  output logic              last_row_o
);

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PRIME = 2'd1;
  localparam logic [1:0] ST_STEP  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic            adv_q, adv_d;

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_valid_q;
  logic [COLS-1:0] rdata_q;
  logic            rvalid_q;

  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [COLS-1:0] wr_data;

  logic [COLS-1:0] above_q, cur_q, top_q;
  logic [COLS-1:0] row_word, below, next_row;

  logic            out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_idx_q;
  logic [ROW_W-1:0] out_bits_q;
  logic            out_last_q;

  logic            in_fire, out_free, step_fire, last_step;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign step_fire  = (state_q == ST_STEP) && out_free;
  assign last_step  = (cnt_q == AW'(ROWS - 1));

  assign row_word = rvalid_q ? rdata_q : '0;
  // bottom row wraps onto the old top row
  assign below    = last_step ? top_q : row_word;

  tlg_row_engine #(
    .COLS (COLS)
  ) u_engine (
    .above_i (above_q),
    .cur_i   (cur_q),
    .below_i (below),
    .next_o  (next_row)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    adv_d   = adv_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (func_i)
            FUNC_LOAD: begin
              if (32'(row_index_i) < ROWS) begin
                wr_en   = 1'b1;
                wr_addr = AW'(row_index_i);
                wr_data = row_bits_i[COLS-1:0];
              end
            end
            FUNC_ADVANCE: begin
              state_d = ST_PRIME;
              adv_d   = 1'b1;
              cnt_d   = '0;
            end
            FUNC_EMIT: begin
              state_d = ST_PRIME;
              adv_d   = 1'b0;
              cnt_d   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_PRIME: begin
        rd_en = 1'b1;
        if (!adv_q) begin
          rd_addr = '0;
          state_d = ST_STEP;
          cnt_d   = '0;
        end else if (cnt_q == AW'(0)) begin
          rd_addr = AW'(ROWS - 1);
          cnt_d   = AW'(1);
        end else if (cnt_q == AW'(1)) begin
          rd_addr = '0;
          cnt_d   = AW'(2);
        end else begin
          rd_addr = AW'(1);
          state_d = ST_STEP;
          cnt_d   = '0;
        end
      end
      ST_STEP: begin
        if (out_free) begin
          if (adv_q) begin
            wr_en   = 1'b1;
            wr_addr = cnt_q;
            wr_data = next_row;
            if (32'(cnt_q) + 2 < ROWS) begin
              rd_en   = 1'b1;
              rd_addr = AW'(32'(cnt_q) + 2);
            end
          end else if (32'(cnt_q) + 1 < ROWS) begin
            rd_en   = 1'b1;
            rd_addr = AW'(32'(cnt_q) + 1);
          end
          if (last_step) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      adv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      adv_q       <= adv_d;
      out_valid_q <= out_valid_d;
      if (rd_en) begin
        rvalid_q <= row_valid_q[rd_addr];
      end
      if (wr_en) begin
        row_valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  // board memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // row window: above, current and saved top row
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PRIME && adv_q && cnt_q == AW'(1)) begin
      above_q <= row_word;
    end else if (state_q == ST_PRIME && adv_q && cnt_q == AW'(2)) begin
      cur_q <= row_word;
      top_q <= row_word;
    end else if (step_fire && adv_q) begin
      above_q <= cur_q;
      cur_q   <= below;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_idx_q  <= IDX_W'(cnt_q);
      out_bits_q <= ROW_W'(adv_q ? next_row : row_word);
      out_last_q <= last_step;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_row_index_o = out_idx_q;
  assign out_row_bits_o  = out_bits_q;
  assign last_row_o      = out_last_q;

endmodule

// ----- hdl/tlg_checker.sv -----
// Port-level checker for toroidal_life_generation, attached by bind.
// Depends on tlg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlg_checker
  import tlg_pkg::*;
#(
  parameter int ROWS = ROWS_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [FUNC_W-1:0] func_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [IDX_W-1:0]  out_row_index_o,
  input logic [ROW_W-1:0]  out_row_bits_o,
  input logic              last_row_o
);

  logic in_fire, sweep_start, load_fire;

  assign in_fire     = in_valid_i && in_ready_o;
  assign sweep_start = in_fire && ((func_i == FUNC_ADVANCE) || (func_i == FUNC_EMIT));
  assign load_fire   = in_fire && (func_i == FUNC_LOAD);

  // reset seen at one edge has cleared the output by the next
  `TLG_ASSERT_ALWAYS(a_reset_no_out, clk_i, !rst_ni |=> !out_valid_o)

  `TLG_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_row_bits_o))

  `TLG_ASSERT(a_last_index, clk_i, rst_ni,
    out_valid_o && last_row_o |-> out_row_index_o == IDX_W'(ROWS - 1))

  `TLG_ASSERT(a_sweep_busy, clk_i, rst_ni, sweep_start |=> !in_ready_o)

  `TLG_ASSERT(a_load_free, clk_i, rst_ni, load_fire |=> in_ready_o)

endmodule

bind toroidal_life_generation tlg_checker #(.ROWS(ROWS)) u_tlg_checker (.*);
